### hdl/decimal_two_address_cpu_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal two-address machine
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TWO_ADDRESS_CPU_CORE_MACROS_SVH
`define DECIMAL_TWO_ADDRESS_CPU_CORE_MACROS_SVH

// same-cycle implication
`define DTAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtac check failed");

// next-cycle implication
`define DTAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtac check failed");

`endif

### hdl/dtac_pkg.sv
// ----------------------------------------------------------------------------
// dtac_pkg
// Types and constants of the decimal two-address machine.
// ----------------------------------------------------------------------------
package dtac_pkg;

  localparam int unsigned AddrW = 17;
  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] ADDR_SCALE = 64'd100000;
  localparam logic [WordW-1:0] OP_SCALE   = 64'd10000000000;
  // first word above the halt opcode range
  localparam logic [WordW-1:0] OP_LIMIT   = 64'd130000000000;
  // floor(t / 3125) = (t * ADDR_RECIP) >> ADDR_SHIFT for t below 2^29
  localparam logic [31:0]      ADDR_RECIP = 32'd703687442;
  localparam int unsigned      ADDR_SHIFT = 41;
  localparam logic [AddrW-1:0] PC_RESET   = 17'd100;

  typedef struct packed {
    logic [1:0]              func;
    logic [AddrW-1:0]        address;
    logic signed [WordW-1:0] data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [WordW-1:0] value;
    logic                    value_valid;
    logic [AddrW-1:0]        program_counter;
  } out_word_t;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_READ  = 2'd1,
    FN_START = 2'd2,
    FN_EXEC  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_HALT    = 3'd1,
    STAT_DIVZ    = 3'd2,
    STAT_ILLEGAL = 3'd3,
    STAT_RANGE   = 3'd4,
    STAT_STOPPED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_COPY = 4'd5,
    OP_RD   = 4'd6,
    OP_WR   = 4'd7,
    OP_BR   = 4'd8,
    OP_BRN  = 4'd9,
    OP_BRZ  = 4'd10,
    OP_BRP  = 4'd11,
    OP_HALT = 4'd12
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDBK, S_FETCH, S_DEC1, S_DEC2, S_RDX, S_RDY,
    S_EXEC, S_MUL_LL, S_MUL_LH, S_MUL_HL, S_MUL_WB, S_DIVW, S_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;

endpackage

### hdl/decimal_two_address_cpu_core.sv
// ----------------------------------------------------------------------------
// decimal_two_address_cpu_core
// Two-address decimal machine around one single-port word memory.
// ----------------------------------------------------------------------------
// Usage: words enter on in_valid/in_ready and each gives exactly one result
// word on out_valid/out_ready. func selects load, read back, start (pc from
// the start address register, which the user writes via cfg_we/cfg_wdata
// while idle; the block does not enforce this) or execute one instruction.
// One word is worked on at a time. An execute fetches, picks the opcode by
// compare, splits the two addresses by reciprocal multiply, reads up to two
// operands and writes back. Multiply adds partial-product steps and divide
// waits on the divider, which sets the worst-case rate.
// The result sits in an output register; the next word is accepted while it
// waits, and a finished result stalls in place until out_ready.
// Reset: a clearing pass writes zero to every memory word, with in_ready low;
// cfg writes are taken during it. pc resets to 100, the machine is stopped,
// the start address is 100.
// ----------------------------------------------------------------------------
`include "decimal_two_address_cpu_core_macros.svh"

module decimal_two_address_cpu_core #(
  parameter int unsigned MEM_WORDS = 131072
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtac_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtac_pkg::out_word_t  out_word
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned PW = dtac_pkg::AddrW;
  localparam int unsigned W  = dtac_pkg::WordW;
  localparam logic [PW:0] MEM_LIMIT = (PW + 1)'(MEM_WORDS);

  logic [W-1:0] mem [MEM_WORDS];
  logic [W-1:0] rdata_r;
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  logic [W-1:0] mem_wdata;

  dtac_pkg::state_t    state_r, state_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [W-1:0]        data_r, data_nxt;
  logic [PW-1:0]       pc_r, pc_nxt;
  logic                running_r, running_nxt;
  logic [PW-1:0]       start_r;
  logic [3:0]          op_r, op_nxt;
  logic [PW-1:0]       a1_r, a1_nxt;
  logic [PW-1:0]       a2_r, a2_nxt;
  logic [W-1:0]        x_r, x_nxt;
  logic [W-1:0]        y_r, y_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        prod_r, prod_nxt;
  logic                negq_r, negq_nxt;
  logic [2:0]          rstat_r, rstat_nxt;
  logic [W-1:0]        rval_r, rval_nxt;
  logic                rvv_r, rvv_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  dtac_pkg::out_word_t out_word_r, out_word_nxt;

  logic [31:0]         mul_a, mul_b;
  logic                x_neg, x_zero, take;
  logic [W-1:0]        quot_s;
  logic [3:0]          dec_op;
  logic [W-1:0]        dec_base, dec_rem;
  logic                dec_legal;
  logic [PW-1:0]       dec_a1, dec_a2;
  logic [33:0]         dec_lo;
  dtac_pkg::div_req_t  div_req;
  dtac_pkg::div_rsp_t  div_rsp;

  dtac_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // single-port memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  assign in_ready  = (state_r == dtac_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    x_neg  = x_r[W-1];
    x_zero = (x_r == '0);
    quot_s = negq_r ? W'(-div_rsp.quot) : div_rsp.quot;
    case (dtac_pkg::opcode_t'(op_r))
      dtac_pkg::OP_BRN: take = x_neg;
      dtac_pkg::OP_BRZ: take = x_zero;
      default:          take = !x_neg && !x_zero;
    endcase
    // opcode: largest multiple of 10^10 not above the fetched word
    dec_op   = '0;
    dec_base = '0;
    for (int k = 1; k <= int'(dtac_pkg::OP_HALT); k++) begin
      if (rdata_r >= W'(k) * dtac_pkg::OP_SCALE) begin
        dec_op   = 4'(k);
        dec_base = W'(k) * dtac_pkg::OP_SCALE;
      end
    end
    dec_legal = (dec_op != '0) && (rdata_r < dtac_pkg::OP_LIMIT);
    dec_rem   = rdata_r - dec_base;
    // address fields from the remainder kept in acc_r and its product
    dec_a1 = prod_r[dtac_pkg::ADDR_SHIFT +: PW];
    dec_lo = acc_r[33:0] - 34'(dec_a1) * 34'(dtac_pkg::ADDR_SCALE);
    dec_a2 = dec_lo[PW-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    data_nxt    = data_r;
    pc_nxt      = pc_r;
    running_nxt = running_r;
    op_nxt      = op_r;
    a1_nxt      = a1_r;
    a2_nxt      = a2_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    negq_nxt    = negq_r;
    rstat_nxt   = rstat_r;
    rval_nxt    = rval_r;
    rvv_nxt     = rvv_r;
    clr_nxt     = clr_r;
    mem_we      = 1'b0;
    mem_addr    = pc_r[AW-1:0];
    mem_wdata   = '0;
    mul_a       = x_r[31:0];
    mul_b       = y_r[31:0];
    div_req     = '{start: 1'b0, num: '0, den: dtac_pkg::ADDR_SCALE};
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;

    case (state_r)
      dtac_pkg::S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = dtac_pkg::S_IDLE;
        end
      end
      dtac_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_word.func;
          data_nxt  = in_word.data;
          rstat_nxt = dtac_pkg::STAT_OK;
          rval_nxt  = '0;
          rvv_nxt   = 1'b0;
          state_nxt = dtac_pkg::S_FIN;
          case (dtac_pkg::func_t'(in_word.func))
            dtac_pkg::FN_LOAD: begin
              mem_addr  = in_word.address[AW-1:0];
              mem_wdata = in_word.data;
              if ({1'b0, in_word.address} < MEM_LIMIT) begin
                mem_we = 1'b1;
              end else begin
                rstat_nxt = dtac_pkg::STAT_RANGE;
              end
            end
            dtac_pkg::FN_READ: begin
              mem_addr = in_word.address[AW-1:0];
              if ({1'b0, in_word.address} < MEM_LIMIT) begin
                state_nxt = dtac_pkg::S_RDBK;
              end else begin
                rstat_nxt = dtac_pkg::STAT_RANGE;
              end
            end
            dtac_pkg::FN_START: begin
              pc_nxt      = start_r;
              running_nxt = 1'b1;
            end
            default: begin
              if (!running_r) begin
                rstat_nxt = dtac_pkg::STAT_STOPPED;
              end else if ({1'b0, pc_r} >= MEM_LIMIT) begin
                rstat_nxt   = dtac_pkg::STAT_RANGE;
                running_nxt = 1'b0;
              end else begin
                state_nxt = dtac_pkg::S_FETCH;
              end
            end
          endcase
        end
      end
      dtac_pkg::S_RDBK: begin
        rval_nxt  = rdata_r;
        rvv_nxt   = 1'b1;
        state_nxt = dtac_pkg::S_FIN;
      end
      dtac_pkg::S_FETCH: begin
        if (rdata_r[W-1] || !dec_legal) begin
          rstat_nxt   = dtac_pkg::STAT_ILLEGAL;
          running_nxt = 1'b0;
          state_nxt   = dtac_pkg::S_FIN;
        end else begin
          op_nxt    = dec_op;
          acc_nxt   = dec_rem;
          state_nxt = dtac_pkg::S_DEC1;
        end
      end
      dtac_pkg::S_DEC1: begin
        // divide by 10^5 as a shift by 5 and a multiply by 1/3125
        mul_a     = {3'b000, acc_r[33:5]};
        mul_b     = dtac_pkg::ADDR_RECIP;
        prod_nxt  = mul_a * mul_b;
        state_nxt = dtac_pkg::S_DEC2;
      end
      dtac_pkg::S_DEC2: begin
        a1_nxt   = dec_a1;
        a2_nxt   = dec_a2;
        mem_addr = dec_a1[AW-1:0];
        if (op_r == dtac_pkg::OP_HALT) begin
          rstat_nxt   = dtac_pkg::STAT_HALT;
          running_nxt = 1'b0;
          state_nxt   = dtac_pkg::S_FIN;
        end else if (op_r == dtac_pkg::OP_BR) begin
          pc_nxt    = dec_a1;
          state_nxt = dtac_pkg::S_FIN;
        end else if ({1'b0, dec_a1} >= MEM_LIMIT ||
                     (op_r <= dtac_pkg::OP_COPY && {1'b0, dec_a2} >= MEM_LIMIT)) begin
          rstat_nxt   = dtac_pkg::STAT_RANGE;
          running_nxt = 1'b0;
          state_nxt   = dtac_pkg::S_FIN;
        end else begin
          state_nxt = dtac_pkg::S_RDX;
        end
      end
      dtac_pkg::S_RDX: begin
        x_nxt    = rdata_r;
        y_nxt    = '0;
        mem_addr = a2_r[AW-1:0];
        state_nxt = (op_r <= dtac_pkg::OP_COPY) ? dtac_pkg::S_RDY : dtac_pkg::S_EXEC;
      end
      dtac_pkg::S_RDY: begin
        y_nxt     = rdata_r;
        state_nxt = dtac_pkg::S_EXEC;
      end
      dtac_pkg::S_EXEC: begin
        mem_addr  = a1_r[AW-1:0];
        pc_nxt    = pc_r + 1'b1;
        state_nxt = dtac_pkg::S_FIN;
        case (dtac_pkg::opcode_t'(op_r))
          dtac_pkg::OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = x_r + y_r;
          end
          dtac_pkg::OP_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = x_r - y_r;
          end
          dtac_pkg::OP_MUL: begin
            pc_nxt    = pc_r;
            state_nxt = dtac_pkg::S_MUL_LL;
          end
          dtac_pkg::OP_DIV: begin
            pc_nxt = pc_r;
            if (y_r == '0) begin
              rstat_nxt   = dtac_pkg::STAT_DIVZ;
              running_nxt = 1'b0;
            end else begin
              div_req.start = 1'b1;
              div_req.num   = x_r[W-1] ? W'(-x_r) : x_r;
              div_req.den   = y_r[W-1] ? W'(-y_r) : y_r;
              negq_nxt      = x_r[W-1] ^ y_r[W-1];
              state_nxt     = dtac_pkg::S_DIVW;
            end
          end
          dtac_pkg::OP_COPY: begin
            mem_we    = 1'b1;
            mem_wdata = y_r;
          end
          dtac_pkg::OP_RD: begin
            mem_we    = 1'b1;
            mem_wdata = data_r;
          end
          dtac_pkg::OP_WR: begin
            rval_nxt = x_r;
            rvv_nxt  = 1'b1;
          end
          default: begin
            if (take) begin
              pc_nxt = a2_r;
            end
          end
        endcase
      end
      dtac_pkg::S_MUL_LL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = dtac_pkg::S_MUL_LH;
      end
      dtac_pkg::S_MUL_LH: begin
        acc_nxt   = prod_r;
        mul_b     = y_r[63:32];
        prod_nxt  = mul_a * mul_b;
        state_nxt = dtac_pkg::S_MUL_HL;
      end
      dtac_pkg::S_MUL_HL: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'b0};
        mul_a     = x_r[63:32];
        prod_nxt  = mul_a * mul_b;
        state_nxt = dtac_pkg::S_MUL_WB;
      end
      dtac_pkg::S_MUL_WB: begin
        mem_addr  = a1_r[AW-1:0];
        mem_we    = 1'b1;
        mem_wdata = acc_r + {prod_r[31:0], 32'b0};
        pc_nxt    = pc_r + 1'b1;
        state_nxt = dtac_pkg::S_FIN;
      end
      dtac_pkg::S_DIVW: begin
        mem_addr = a1_r[AW-1:0];
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = quot_s;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = dtac_pkg::S_FIN;
        end
      end
      dtac_pkg::S_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: rstat_r, value: rval_r, value_valid: rvv_r,
                            program_counter: pc_r};
          state_nxt     = dtac_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dtac_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtac_pkg::S_CLR;
      clr_r       <= '0;
      pc_r        <= dtac_pkg::PC_RESET;
      running_r   <= 1'b0;
      start_r     <= dtac_pkg::PC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
    end
    func_r     <= func_nxt;
    data_r     <= data_nxt;
    op_r       <= op_nxt;
    a1_r       <= a1_nxt;
    a2_r       <= a2_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    negq_r     <= negq_nxt;
    rstat_r    <= rstat_nxt;
    rval_r     <= rval_nxt;
    rvv_r      <= rvv_nxt;
    out_word_r <= out_word_nxt;
  end

  `DTAC_ASSERT_IMP(a_div_done_expected, div_rsp.done, state_r == dtac_pkg::S_DIVW)
  `DTAC_ASSERT_NXT(a_stop_on_fault, state_r == dtac_pkg::S_FIN && func_r == dtac_pkg::FN_EXEC &&
    rstat_r != dtac_pkg::STAT_OK && rstat_r != dtac_pkg::STAT_STOPPED, !running_r)
  `DTAC_ASSERT_IMP(a_value_source, state_r == dtac_pkg::S_FIN && rvv_r,
    func_r == dtac_pkg::FN_READ || func_r == dtac_pkg::FN_EXEC)
  `DTAC_ASSERT_IMP(a_no_accept_clearing, state_r == dtac_pkg::S_CLR, !in_ready)

endmodule

### hdl/dtac_div.sv
// ----------------------------------------------------------------------------
// dtac_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtac_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dtac_pkg::div_req_t req,
  output dtac_pkg::div_rsp_t rsp
);

  localparam int unsigned W  = dtac_pkg::WordW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic          ge;

  always_comb begin
    trial    = {r_r, q_r[W-1]};
    ge       = trial >= {1'b0, d_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt   = req.num;
      r_nxt   = '0;
      d_nxt   = req.den;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      r_nxt   = ge ? W'(trial - {1'b0, d_r}) : trial[W-1:0];
      q_nxt   = {q_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      // last quotient bit lands this edge
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule
